FILE: rtl/core/tcre_pkg.sv
// Shared types and constants of the tile column classifier and run extractor.
// Holds the beat payload structs, the band summary struct and field widths.
// Depends on nothing; the band classifier and the top level refer to it by scoped names.
package tcre_pkg;

    localparam int COLUMNS_DEF = 32;
    localparam int ROWS_DEF    = 15;

    localparam int PIX_W     = 8;
    localparam int COL_W     = 5;
    localparam int ROW_W     = 4;
    localparam int CNT_W     = 5;
    localparam int MASK_W    = 15;
    localparam int SLOT_W    = 9;
    localparam int ADDR_W    = 16;
    localparam int TOTAL_W   = 9;
    localparam int COLCMP_W  = 7;
    localparam int BAND_SHIFT = 3;
    localparam int BAND_LAST  = 7;
    localparam int TOTAL_MAX  = 511;
    localparam int ROW_MAX    = 15;
    localparam int SAMPLES    = 4;
    localparam int SAMPLE_W   = 2;

    typedef struct packed {
        logic              frame_start;
        logic [ADDR_W-1:0] bank_base;
        logic [COL_W-1:0]  column_index;
        logic [PIX_W-1:0]  wall_top_a;
        logic [PIX_W-1:0]  wall_top_b;
        logic [PIX_W-1:0]  wall_top_c;
        logic [PIX_W-1:0]  wall_top_d;
        logic [PIX_W-1:0]  wall_bottom_a;
        logic [PIX_W-1:0]  wall_bottom_b;
        logic [PIX_W-1:0]  wall_bottom_c;
        logic [PIX_W-1:0]  wall_bottom_d;
    } t_in_beat;

    typedef struct packed {
        logic [COL_W-1:0]   out_column;
        logic               run_valid;
        logic [ROW_W-1:0]   run_first_row;
        logic [ROW_W-1:0]   run_length;
        logic [SLOT_W-1:0]  slot_index;
        logic [ADDR_W-1:0]  upload_address;
        logic [MASK_W-1:0]  dyn_row_mask;
        logic [ROW_W-1:0]   column_tiles;
        logic [TOTAL_W-1:0] frame_tiles;
        logic [TOTAL_W-1:0] frame_runs;
        logic               is_last;
    } t_out_beat;

    // Summary of one column: the dynamic rows always form a single range.
    typedef struct packed {
        logic              any;
        logic [ROW_W-1:0]  first;
        logic [CNT_W-1:0]  tiles;
        logic [MASK_W-1:0] mask;
    } t_band;

endpackage

FILE: rtl/core/tcre_stream_if.sv
// Valid/ready stream interface used for the input and the result channel.
// The payload type is set per instance from the structs in tcre_pkg.
interface tcre_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/tcre_band.sv
// Band classifier: turns the lowest wall top and highest wall bottom of a
// column into its dynamic row range, mask and tile count. Uses tcre_pkg.
module tcre_band #(
    parameter int ROWS = tcre_pkg::ROWS_DEF
) (
    input  logic [tcre_pkg::PIX_W-1:0] i_min_top,
    input  logic [tcre_pkg::PIX_W-1:0] i_max_bot,
    input  logic                       i_col_ok,
    output tcre_pkg::t_band            o_band
);
    logic [tcre_pkg::CNT_W-1:0] lo;
    logic [tcre_pkg::CNT_W:0]   hi;
    logic [tcre_pkg::CNT_W:0]   hi_c;
    logic [tcre_pkg::PIX_W:0]   bot_round;
    logic                       any;

    // A band is ceiling while its row is below min_top/8, and floor from
    // ceil(max_bot/8) on; the rows in between are dynamic.
    always_comb begin
        lo        = tcre_pkg::CNT_W'(i_min_top >> tcre_pkg::BAND_SHIFT);
        bot_round = {1'b0, i_max_bot} + (tcre_pkg::PIX_W+1)'(tcre_pkg::BAND_LAST);
        hi        = (tcre_pkg::CNT_W+1)'(bot_round >> tcre_pkg::BAND_SHIFT);
        hi_c      = (hi > (tcre_pkg::CNT_W+1)'(ROWS)) ? (tcre_pkg::CNT_W+1)'(ROWS) : hi;
        any       = i_col_ok && ({1'b0, lo} < hi_c);

        o_band.any   = any;
        o_band.first = any ? lo[tcre_pkg::ROW_W-1:0] : '0;
        o_band.tiles = any ? tcre_pkg::CNT_W'(hi_c - {1'b0, lo}) : '0;
        for (int y = 0; y < tcre_pkg::MASK_W; y++) begin
            o_band.mask[y] = any && ((tcre_pkg::CNT_W+1)'(y) >= {1'b0, lo})
                                 && ((tcre_pkg::CNT_W+1)'(y) < hi_c);
        end
    end
endmodule

FILE: rtl/core/tile_column_classify_and_run_extract.sv
// Top level of the tile column classifier and run extractor.
// Depends on tcre_pkg, tcre_stream_if and tcre_band.
//
// Usage:
// i_in carries one tile column per beat: frame_start, bank_base, column_index
// and four wall top and four wall bottom pixel rows. o_out carries the result
// beats. Because the dynamic rows of a column always form one contiguous
// range, every column gives exactly one result beat, with is_last set; it
// describes the run, or has run_valid 0 when the column has no dynamic row.
// Timing: after an input beat is taken, the wall samples are folded into a
// lowest top and highest bottom by one shared comparator pair, one sample
// per cycle; then the build step registers the range and the slot product,
// and the issue step adds the upload address and frame totals into the output
// register. The result is offered in the same cycle that i_in.ready returns,
// so a new column is only taken once the last one has been issued.
// The output register parts both sides: a new column is taken while the last
// result still waits. If the receiver stalls, the next column stops in its
// final step until the output register is free.
// Reset clears the sequencer, the output valid and both frame totals.
module tile_column_classify_and_run_extract #(
    parameter int COLUMNS = tcre_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcre_pkg::ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcre_stream_if.sink   i_in,
    tcre_stream_if.source o_out
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_FOLD,
        S_BUILD,
        S_ISSUE
    } t_state;

    t_state                          r_state, n_state;
    logic [tcre_pkg::SAMPLE_W-1:0]   r_k, n_k;
    tcre_pkg::t_in_beat              r_item;
    logic [tcre_pkg::PIX_W-1:0]      r_tops [tcre_pkg::SAMPLES];
    logic [tcre_pkg::PIX_W-1:0]      r_bots [tcre_pkg::SAMPLES];
    logic [tcre_pkg::PIX_W-1:0]      r_min_top, n_min_top;
    logic [tcre_pkg::PIX_W-1:0]      r_max_bot, n_max_bot;
    tcre_pkg::t_band                 r_band;
    logic [tcre_pkg::SLOT_W-1:0]     r_slot;
    logic [tcre_pkg::TOTAL_W-1:0]    r_tile_total, n_tile_total;
    logic [tcre_pkg::TOTAL_W-1:0]    r_run_total, n_run_total;
    logic                            r_out_valid, n_out_valid;
    tcre_pkg::t_out_beat             r_out, n_out;

    logic                            in_fire;
    logic                            out_free;
    logic                            issue;
    logic                            col_ok;
    tcre_pkg::t_band                 band;
    logic [tcre_pkg::PIX_W-1:0]      sel_top, sel_bot;
    logic [tcre_pkg::SLOT_W:0]       slot_sum;
    logic [tcre_pkg::TOTAL_W-1:0]    tile_base, run_base;
    logic [tcre_pkg::TOTAL_W:0]      tile_sum, run_sum;
    logic [tcre_pkg::ROW_W-1:0]      tiles_sat;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign issue     = (r_state == S_ISSUE) && out_free;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign col_ok = (tcre_pkg::COLCMP_W'(r_item.column_index) < tcre_pkg::COLCMP_W'(COLUMNS));

    tcre_band #(
        .ROWS (ROWS)
    ) u_band (
        .i_min_top (r_min_top),
        .i_max_bot (r_max_bot),
        .i_col_ok  (col_ok),
        .o_band    (band)
    );

    always_comb begin
        sel_top   = r_tops[r_k];
        sel_bot   = r_bots[r_k];
        // Shared comparator pair: one sample folded in per cycle.
        n_min_top = (sel_top < r_min_top) ? sel_top : r_min_top;
        n_max_bot = (sel_bot > r_max_bot) ? sel_bot : r_max_bot;
        n_k       = r_k + 1'b1;

        slot_sum  = (tcre_pkg::SLOT_W+1)'(r_item.column_index) * (tcre_pkg::SLOT_W+1)'(ROWS)
                  + (tcre_pkg::SLOT_W+1)'(band.first);

        tile_base = r_item.frame_start ? '0 : r_tile_total;
        run_base  = r_item.frame_start ? '0 : r_run_total;
        tile_sum  = {1'b0, tile_base} + (tcre_pkg::TOTAL_W+1)'(r_band.tiles);
        run_sum   = {1'b0, run_base} + (tcre_pkg::TOTAL_W+1)'(r_band.any);
        n_tile_total = (tile_sum > (tcre_pkg::TOTAL_W+1)'(tcre_pkg::TOTAL_MAX))
                     ? tcre_pkg::TOTAL_W'(tcre_pkg::TOTAL_MAX) : tile_sum[tcre_pkg::TOTAL_W-1:0];
        n_run_total  = (run_sum > (tcre_pkg::TOTAL_W+1)'(tcre_pkg::TOTAL_MAX))
                     ? tcre_pkg::TOTAL_W'(tcre_pkg::TOTAL_MAX) : run_sum[tcre_pkg::TOTAL_W-1:0];

        tiles_sat = (r_band.tiles > tcre_pkg::CNT_W'(tcre_pkg::ROW_MAX))
                  ? tcre_pkg::ROW_W'(tcre_pkg::ROW_MAX) : r_band.tiles[tcre_pkg::ROW_W-1:0];

        n_out.out_column     = r_item.column_index;
        n_out.run_valid      = r_band.any;
        n_out.run_first_row  = r_band.first;
        n_out.run_length     = tiles_sat;
        n_out.slot_index     = r_band.any ? r_slot : '0;
        n_out.upload_address = r_band.any
                             ? r_item.bank_base + tcre_pkg::ADDR_W'(r_slot) : '0;
        n_out.dyn_row_mask   = r_band.mask;
        n_out.column_tiles   = tiles_sat;
        n_out.frame_tiles    = n_tile_total;
        n_out.frame_runs     = n_run_total;
        n_out.is_last        = 1'b1;

        n_out_valid = issue || (r_out_valid && !o_out.ready);

        case (r_state)
            S_IDLE:  n_state = in_fire ? S_FOLD : S_IDLE;
            S_FOLD:  n_state = (r_k == tcre_pkg::SAMPLE_W'(tcre_pkg::SAMPLES - 1))
                             ? S_BUILD : S_FOLD;
            S_BUILD: n_state = S_ISSUE;
            S_ISSUE: n_state = out_free ? S_IDLE : S_ISSUE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
            r_tile_total <= '0;
            r_run_total  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    r_k <= tcre_pkg::SAMPLE_W'(1);
                end
                S_FOLD: begin
                    r_k <= n_k;
                end
                S_ISSUE: begin
                    if (out_free) begin
                        r_tile_total <= n_tile_total;
                        r_run_total  <= n_run_total;
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end

        if (in_fire) begin
            r_item    <= i_in.data;
            r_tops[0] <= i_in.data.wall_top_a;
            r_tops[1] <= i_in.data.wall_top_b;
            r_tops[2] <= i_in.data.wall_top_c;
            r_tops[3] <= i_in.data.wall_top_d;
            r_bots[0] <= i_in.data.wall_bottom_a;
            r_bots[1] <= i_in.data.wall_bottom_b;
            r_bots[2] <= i_in.data.wall_bottom_c;
            r_bots[3] <= i_in.data.wall_bottom_d;
            r_min_top <= i_in.data.wall_top_a;
            r_max_bot <= i_in.data.wall_bottom_a;
        end else if (r_state == S_FOLD) begin
            r_min_top <= n_min_top;
            r_max_bot <= n_max_bot;
        end
        if (r_state == S_BUILD) begin
            r_band <= band;
            r_slot <= slot_sum[tcre_pkg::SLOT_W-1:0];
        end
        if (issue) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_FOLD))
        else $error("accepted column did not enter the fold step");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.is_last)
        else $error("result beat without is_last");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.run_valid) |->
            (o_out.data.run_length == '0 && o_out.data.dyn_row_mask == '0
             && o_out.data.upload_address == '0))
        else $error("empty column result carries run data");

    a_run_matches_tiles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.run_valid) |->
            (o_out.data.run_length == o_out.data.column_tiles
             && o_out.data.run_length != '0))
        else $error("run length differs from column tile count");
`endif
endmodule
